@@ hdl/dag_shortest_path_topo_defines.svh @@
// Assertion macros used by the file that carries checks.
`ifndef DAG_SHORTEST_PATH_TOPO_DEFINES_SVH
`define DAG_SHORTEST_PATH_TOPO_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define DAGSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dagsp check failed");

// Next-cycle implication, ignored while reset is high.
`define DAGSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dagsp check failed");

`endif

@@ hdl/dagsp_pkg.sv @@
package dagsp_pkg;

  // Field widths fixed by the interface.
  localparam int NODE_W = 6;
  localparam int CNT_W  = 7;
  localparam int COST_W = 16;
  localparam int DIST_W = 22;

  // Default sizes of the stores.
  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_MAX_EDGES = 1024;

  // Configuration register indexes and reset values.
  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_SOURCE     = 1'b1;
  localparam logic [CNT_W-1:0]  NODE_COUNT_RST = 7'd64;
  localparam logic [NODE_W-1:0] SOURCE_RST     = 6'd0;

  // Request commands.
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_SOLVE  = 1'b1;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 22'sh1FFFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 22'sh200000;

  // Clamp a one-bit-wider sum back into the distance range.
  function automatic logic signed [DIST_W-1:0] sat_dist(input logic signed [DIST_W:0] v);
    logic signed [DIST_W-1:0] r;
    if (v[DIST_W] != v[DIST_W-1]) begin
      r = v[DIST_W] ? DIST_MIN : DIST_MAX;
    end else begin
      r = v[DIST_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/dagsp_ram.sv @@
module dagsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/dag_shortest_path_topo.sv @@
// Channel   Direction  Handshake               Payload
// in        sink       in_valid / in_ready     cmd, edge_from, edge_to, edge_weight
// out       source     out_valid / out_ready   node_index, distance, reachable,
//                                              edges_dropped, last
// cfg       sink       cfg_we                  cfg_index, cfg_data
//
// A stored append does a list RAM read, then the linked-list write-back.
// A dropped append leaves the block idle. A solve request is accepted, then runs a
// depth-first walk and relaxation over the edges stored, then streams the results
// while the receiver is ready; every step waits on the registered reads of the
// edge, list and distance RAMs.
// Synchronous reset needs no clearing pass: list occupancy lives in flip-flops.
// A stalled result holds the block; no new request is taken until the last result goes.
`include "dag_shortest_path_topo_defines.svh"

module dag_shortest_path_topo #(
  parameter int MAX_NODES = dagsp_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = dagsp_pkg::DEF_MAX_EDGES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic [dagsp_pkg::NODE_W-1:0]      edge_from,
  input  logic [dagsp_pkg::NODE_W-1:0]      edge_to,
  input  logic signed [dagsp_pkg::COST_W-1:0] edge_weight,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dagsp_pkg::NODE_W-1:0]      node_index,
  output logic signed [dagsp_pkg::DIST_W-1:0] distance,
  output logic                              reachable,
  output logic                              edges_dropped,
  output logic                              last,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [dagsp_pkg::CNT_W-1:0]       cfg_data
);
  import dagsp_pkg::*;

  localparam int NAW = $clog2(MAX_NODES);
  localparam int EAW = $clog2(MAX_EDGES);

  typedef struct packed {
    logic [EAW-1:0] head;
    logic [EAW-1:0] tail;
  } list_t;

  typedef struct packed {
    logic [NAW-1:0] node;
    logic [EAW-1:0] e;
    logic           has;
    logic [EAW-1:0] tail;
  } frame_t;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_LOAD  = 16'h0002,
    S_ROOT  = 16'h0004,
    S_DHEAD = 16'h0008,
    S_DSTEP = 16'h0010,
    S_DEDGE = 16'h0020,
    S_DPOP  = 16'h0040,
    S_RNODE = 16'h0080,
    S_RLOAD = 16'h0100,
    S_RHEAD = 16'h0200,
    S_RSTEP = 16'h0400,
    S_REDGE = 16'h0800,
    S_RCMP  = 16'h1000,
    S_ORD   = 16'h2000,
    S_OLOAD = 16'h4000,
    S_OWAIT = 16'h8000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  node_count;
  logic [NODE_W-1:0] source_node;
  logic [CNT_W-1:0]  n_eff;

  logic [EAW:0]      edge_total;
  logic              drop_seen;
  logic [MAX_NODES-1:0] nonempty;
  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] reached;

  // Pending append.
  logic [NAW-1:0]           ld_from;
  logic [NODE_W-1:0]        ld_to;
  logic signed [COST_W-1:0] ld_w;
  logic [EAW-1:0]           ld_e;

  // Walk registers.
  logic [CNT_W-1:0] root;
  logic [NAW-1:0]   sp;
  logic [NAW:0]     count;
  logic [NAW:0]     k;
  logic [NAW-1:0]   cur_node;
  logic [EAW-1:0]   cur_e;
  logic [EAW-1:0]   cur_tail;
  logic             cur_has;
  logic signed [DIST_W-1:0] cur_dist;
  logic signed [DIST_W-1:0] cand_r;
  logic [NAW-1:0]   rel_t;
  logic [CNT_W-1:0] out_i;

  // RAM ports.
  logic list_we;  logic [NAW-1:0] list_waddr, list_raddr; list_t list_wdata, list_rd;
  logic info_we;  logic [EAW-1:0] info_waddr;
  logic [NODE_W+COST_W-1:0] info_wdata, info_rd;
  logic next_we;  logic [EAW-1:0] next_waddr, next_wdata, next_rd;
  logic stk_we;   logic [NAW-1:0] stk_waddr, stk_raddr; frame_t stk_wdata, stk_rd;
  logic topo_we;  logic [NAW-1:0] topo_waddr, topo_raddr, topo_wdata, topo_rd;
  logic dist_we;  logic [NAW-1:0] dist_waddr, dist_raddr;
  logic [DIST_W-1:0] dist_wdata, dist_rd;

  logic                     in_fire, drop_cond, src_ok, adv_has, push_ok, upd;
  logic [NODE_W-1:0]        tgt;
  logic signed [COST_W-1:0] w_rd;
  logic signed [DIST_W-1:0] cand;

  // Effective node count, clamped between one and the store size.
  always_comb begin
    if (node_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (node_count > CNT_W'(MAX_NODES)) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = node_count;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign drop_cond = ({1'b0, edge_from} >= n_eff) || ({1'b0, edge_to} >= n_eff) ||
                     (edge_total >= (EAW+1)'(MAX_EDGES));
  assign src_ok    = ({1'b0, source_node} < n_eff);

  assign tgt     = info_rd[NODE_W+COST_W-1:COST_W];
  assign w_rd    = info_rd[COST_W-1:0];
  assign adv_has = (cur_e != cur_tail);
  assign push_ok = ({1'b0, tgt} < n_eff) && !visited[tgt[NAW-1:0]] &&
                   ((NAW+1)'(sp) + (NAW+1)'(1) < (NAW+1)'(MAX_NODES));
  assign cand    = sat_dist((DIST_W+1)'(cur_dist) + (DIST_W+1)'(w_rd));
  assign upd     = !reached[rel_t] || ($signed(cand_r) < $signed(dist_rd));

  // RAM port control.
  always_comb begin
    list_we    = (state == S_LOAD);
    list_waddr = ld_from;
    list_wdata = nonempty[ld_from] ? '{head: list_rd.head, tail: ld_e}
                                   : '{head: ld_e, tail: ld_e};
    case (state)
      S_IDLE:  list_raddr = edge_from[NAW-1:0];
      S_ROOT:  list_raddr = root[NAW-1:0];
      S_DEDGE: list_raddr = tgt[NAW-1:0];
      S_RLOAD: list_raddr = topo_rd;
      default: list_raddr = '0;
    endcase

    info_we    = (state == S_LOAD);
    info_waddr = ld_e;
    info_wdata = {ld_to, ld_w};
    next_we    = (state == S_LOAD) && nonempty[ld_from];
    next_waddr = list_rd.tail;
    next_wdata = ld_e;

    stk_we    = (state == S_DEDGE) && push_ok;
    stk_waddr = sp;
    stk_wdata = '{node: cur_node, e: next_rd, has: adv_has, tail: cur_tail};
    stk_raddr = sp - NAW'(1);

    topo_we    = (state == S_DSTEP) && !cur_has;
    topo_waddr = count[NAW-1:0];
    topo_wdata = cur_node;
    topo_raddr = NAW'(k - (NAW+1)'(1));

    if (state == S_IDLE) begin
      dist_we    = in_fire && (cmd == CMD_SOLVE) && src_ok;
      dist_waddr = source_node[NAW-1:0];
      dist_wdata = '0;
    end else begin
      dist_we    = (state == S_RCMP) && upd;
      dist_waddr = rel_t;
      dist_wdata = cand_r;
    end
    case (state)
      S_RLOAD: dist_raddr = topo_rd;
      S_REDGE: dist_raddr = tgt[NAW-1:0];
      S_ORD:   dist_raddr = out_i[NAW-1:0];
      default: dist_raddr = '0;
    endcase
  end

  dagsp_ram #(.WIDTH(2*EAW), .DEPTH(MAX_NODES)) u_list (
    .clk, .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
    .raddr(list_raddr), .rdata(list_rd));

  dagsp_ram #(.WIDTH(NODE_W+COST_W), .DEPTH(MAX_EDGES)) u_info (
    .clk, .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
    .raddr(cur_e), .rdata(info_rd));

  dagsp_ram #(.WIDTH(EAW), .DEPTH(MAX_EDGES)) u_next (
    .clk, .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(cur_e), .rdata(next_rd));

  dagsp_ram #(.WIDTH(NAW+2*EAW+1), .DEPTH(MAX_NODES)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd));

  dagsp_ram #(.WIDTH(NAW), .DEPTH(MAX_NODES)) u_topo (
    .clk, .we(topo_we), .waddr(topo_waddr), .wdata(topo_wdata),
    .raddr(topo_raddr), .rdata(topo_rd));

  dagsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist (
    .clk, .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .raddr(dist_raddr), .rdata(dist_rd));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= NODE_COUNT_RST;
      source_node <= SOURCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NODE_COUNT: node_count  <= cfg_data;
        REG_SOURCE:     source_node <= cfg_data[NODE_W-1:0];
        default:        ;
      endcase
    end
  end

  // Sequencer: load, depth-first walk, relaxation, result stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      edge_total <= '0;
      drop_seen  <= 1'b0;
      nonempty   <= '0;
      visited    <= '0;
      reached    <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (cmd == CMD_APPEND) begin
              if (drop_cond) begin
                drop_seen <= 1'b1;
              end else begin
                ld_from <= edge_from[NAW-1:0];
                ld_to   <= edge_to;
                ld_w    <= edge_weight;
                ld_e    <= edge_total[EAW-1:0];
                state   <= S_LOAD;
              end
            end else begin
              // Only the source starts out reached.
              visited <= '0;
              reached <= src_ok ? (MAX_NODES'(1) << source_node[NAW-1:0]) : '0;
              root  <= '0;
              sp    <= '0;
              count <= '0;
              state <= S_ROOT;
            end
          end
        end
        S_LOAD: begin
          nonempty[ld_from] <= 1'b1;
          edge_total        <= edge_total + (EAW+1)'(1);
          state             <= S_IDLE;
        end
        S_ROOT: begin
          if (root >= n_eff) begin
            k     <= count;
            state <= S_RNODE;
          end else if (visited[root[NAW-1:0]]) begin
            root <= root + CNT_W'(1);
          end else begin
            visited[root[NAW-1:0]] <= 1'b1;
            cur_node <= root[NAW-1:0];
            state    <= S_DHEAD;
          end
        end
        S_DHEAD: begin
          cur_e    <= list_rd.head;
          cur_tail <= list_rd.tail;
          cur_has  <= nonempty[cur_node];
          state    <= S_DSTEP;
        end
        S_DSTEP: begin
          if (cur_has) begin
            state <= S_DEDGE;
          end else begin
            count <= count + (NAW+1)'(1);
            if (sp == '0) begin
              root  <= root + CNT_W'(1);
              state <= S_ROOT;
            end else begin
              sp    <= sp - NAW'(1);
              state <= S_DPOP;
            end
          end
        end
        S_DEDGE: begin
          if (push_ok) begin
            visited[tgt[NAW-1:0]] <= 1'b1;
            sp       <= sp + NAW'(1);
            cur_node <= tgt[NAW-1:0];
            state    <= S_DHEAD;
          end else begin
            cur_e   <= next_rd;
            cur_has <= adv_has;
            state   <= S_DSTEP;
          end
        end
        S_DPOP: begin
          cur_node <= stk_rd.node;
          cur_e    <= stk_rd.e;
          cur_has  <= stk_rd.has;
          cur_tail <= stk_rd.tail;
          state    <= S_DSTEP;
        end
        S_RNODE: begin
          if (k == '0) begin
            out_i <= '0;
            state <= S_ORD;
          end else begin
            k     <= k - (NAW+1)'(1);
            state <= S_RLOAD;
          end
        end
        S_RLOAD: begin
          if (reached[topo_rd]) begin
            cur_node <= topo_rd;
            cur_has  <= nonempty[topo_rd];
            state    <= S_RHEAD;
          end else begin
            state <= S_RNODE;
          end
        end
        S_RHEAD: begin
          cur_dist <= dist_rd;
          cur_e    <= list_rd.head;
          cur_tail <= list_rd.tail;
          state    <= S_RSTEP;
        end
        S_RSTEP: begin
          state <= cur_has ? S_REDGE : S_RNODE;
        end
        S_REDGE: begin
          cur_e   <= next_rd;
          cur_has <= adv_has;
          if ({1'b0, tgt} < n_eff) begin
            rel_t  <= tgt[NAW-1:0];
            cand_r <= cand;
            state  <= S_RCMP;
          end else begin
            state <= S_RSTEP;
          end
        end
        S_RCMP: begin
          // A self-loop updates the distance used for the rest of this list.
          if (upd) begin
            reached[rel_t] <= 1'b1;
            if (rel_t == cur_node) begin
              cur_dist <= cand_r;
            end
          end
          state <= S_RSTEP;
        end
        S_ORD: begin
          state <= S_OLOAD;
        end
        S_OLOAD: begin
          node_index    <= out_i[NODE_W-1:0];
          distance      <= reached[out_i[NAW-1:0]] ? dist_rd : '0;
          reachable     <= reached[out_i[NAW-1:0]];
          edges_dropped <= drop_seen;
          last          <= (out_i == n_eff - CNT_W'(1));
          out_valid     <= 1'b1;
          state         <= S_OWAIT;
        end
        S_OWAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              nonempty   <= '0;
              edge_total <= '0;
              drop_seen  <= 1'b0;
              state      <= S_IDLE;
            end else begin
              out_i <= out_i + CNT_W'(1);
              state <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer.
  `DAGSP_ASSERT_NOW(a_idle_no_result, in_ready, !out_valid)
  `DAGSP_ASSERT_NEXT(a_last_frees_input, out_valid && out_ready && last, in_ready)
  `DAGSP_ASSERT_NOW(a_edge_bound, 1'b1, edge_total <= (EAW+1)'(MAX_EDGES))
  `DAGSP_ASSERT_NEXT(a_append_two_cycles, in_fire && (cmd == CMD_APPEND) && !drop_cond,
                     !in_ready)

endmodule
